### hw/rtl/ctps_pkg.sv
// ----------------------------------------------------------------------------
// ctps_pkg
// Shared types and codes of the cone turning pass sequencer: commands, move
// kinds, pass phases, register indexes and the state and result records.
// ----------------------------------------------------------------------------
package ctps_pkg;

   localparam int unsigned DepthW = 20;
   localparam int unsigned PosW   = 24;
   localparam int unsigned FactW  = 25;
   localparam int unsigned FeedW  = 16;
   localparam int unsigned CsrAW  = 3;

   // register indexes
   localparam logic [CsrAW-1:0] REG_TOTAL_DEPTH  = 3'd0;
   localparam logic [CsrAW-1:0] REG_ROUGH_DEPTH  = 3'd1;
   localparam logic [CsrAW-1:0] REG_FINISH_DEPTH = 3'd2;
   localparam logic [CsrAW-1:0] REG_RETRACT_DIST = 3'd3;
   localparam logic [CsrAW-1:0] REG_X_PER_DEPTH  = 3'd4;
   localparam logic [CsrAW-1:0] REG_Z_PER_DEPTH  = 3'd5;
   localparam logic [CsrAW-1:0] REG_ROUGH_FEED   = 3'd6;
   localparam logic [CsrAW-1:0] REG_FINISH_FEED  = 3'd7;

   localparam logic signed [FactW-1:0] FACTOR_ONE = 25'sd65536;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_DONE  = 2'd1,
      CMD_ERROR = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      MOVE_SPINDLE  = 3'd0,
      MOVE_RAPID_X  = 3'd1,
      MOVE_FEED_XZ  = 3'd2,
      MOVE_RAPID_XZ = 3'd3,
      MOVE_DONE     = 3'd4
   } move_kind_type;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_PLUNGE  = 5'b00010,
      PH_CUT     = 5'b00100,
      PH_RETRACT = 5'b01000,
      PH_RETURN  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic        [DepthW-1:0] total_depth;
      logic        [DepthW-1:0] rough_depth;
      logic        [DepthW-1:0] finish_depth;
      logic        [DepthW-1:0] retract_dist;
      logic signed [FactW-1:0]  x_per_depth;
      logic signed [FactW-1:0]  z_per_depth;
      logic        [FeedW-1:0]  rough_feed;
      logic        [FeedW-1:0]  finish_feed;
   } cfg_type;

   typedef struct packed {
      phase_type                phase;
      logic        [DepthW-1:0] cut_depth;
      logic signed [PosW-1:0]   origin_x;
      logic signed [PosW-1:0]   origin_z;
      logic signed [PosW-1:0]   z_target;
      logic        [FeedW-1:0]  active_feed;
   } state_type;

   typedef struct packed {
      move_kind_type            move_kind;
      logic signed [PosW-1:0]   target_x;
      logic signed [PosW-1:0]   target_z;
      logic        [FeedW-1:0]  feed_rate;
   } rsp_type;

endpackage

### hw/rtl/ctps_step.sv
// ----------------------------------------------------------------------------
// ctps_step
// Next state and move of the pass sequencer for one request: pass depth
// choice, one shared depth multiplier with rounding, and target saturation.
// ----------------------------------------------------------------------------
module ctps_step (
   input  ctps_pkg::cmd_type                 cmd,
   input  logic signed [ctps_pkg::PosW-1:0]  start_x,
   input  logic signed [ctps_pkg::PosW-1:0]  start_z,
   input  ctps_pkg::cfg_type                 cfg,
   input  ctps_pkg::state_type               cur,
   output ctps_pkg::state_type               nxt,
   output logic                              has_rsp,
   output ctps_pkg::rsp_type                 rsp
);
   import ctps_pkg::*;

   localparam int unsigned OpW   = DepthW + 2;
   localparam int unsigned ProdW = OpW + FactW;
   localparam int unsigned RndW  = 32;
   localparam int unsigned SumW  = RndW + 1;

   function automatic logic signed [PosW-1:0] sat_pos(input logic signed [SumW-1:0] v);
      logic signed [SumW-1:0] lo;
      logic signed [SumW-1:0] hi;
      lo = -(SumW'(1) <<< (PosW - 1));
      hi = (SumW'(1) <<< (PosW - 1)) - SumW'(1);
      if (v < lo) begin
         sat_pos = lo[PosW-1:0];
      end else if (v > hi) begin
         sat_pos = hi[PosW-1:0];
      end else begin
         sat_pos = v[PosW-1:0];
      end
   endfunction

   logic signed [OpW-1:0]     diff;
   logic signed [OpW-1:0]     rough_plus_finish;
   logic signed [OpW-1:0]     finish_plus_one;
   logic                      take_rough;
   logic                      take_finish;
   logic        [DepthW-1:0]  new_cut;
   logic signed [OpW-1:0]     op_a;
   logic signed [FactW-1:0]   op_b;
   logic signed [ProdW-1:0]   prod;
   logic                      shift17;
   logic signed [ProdW:0]     prod_half;
   logic signed [ProdW:0]     prod_rnd;
   logic signed [RndW-1:0]    rnd;
   logic signed [SumW-1:0]    base;
   logic signed [SumW-1:0]    pos_sum;
   logic signed [PosW-1:0]    pos_sat;

   // pass depth choice
   always_comb begin
      diff              = $signed({2'b00, cfg.total_depth}) - $signed({2'b00, cur.cut_depth});
      rough_plus_finish = $signed({2'b00, cfg.rough_depth}) + $signed({2'b00, cfg.finish_depth});
      finish_plus_one   = $signed({2'b00, cfg.finish_depth}) + OpW'(1);
      take_rough        = diff >= rough_plus_finish;
      take_finish       = !take_rough && (diff <= finish_plus_one);
      priority if (take_rough) begin
         new_cut = cur.cut_depth + cfg.rough_depth;
      end else if (take_finish) begin
         new_cut = cfg.total_depth;
      end else begin
         new_cut = cfg.total_depth - cfg.finish_depth;
      end
   end

   // shared multiplier, rounding half up after the shift
   always_comb begin
      op_b    = cfg.x_per_depth;
      shift17 = 1'b0;
      unique case (cur.phase)
         PH_PLUNGE: begin
            op_a    = $signed({2'b00, new_cut});
            shift17 = 1'b1;
         end
         PH_CUT: begin
            op_a = $signed({2'b00, cur.cut_depth});
            op_b = cfg.z_per_depth;
         end
         PH_RETRACT: begin
            op_a = $signed({2'b00, cfg.retract_dist});
         end
         PH_RETURN: begin
            op_a    = $signed({2'b00, cur.cut_depth}) - $signed({2'b00, cfg.retract_dist});
            shift17 = 1'b1;
         end
         default: begin
            op_a = '0;
         end
      endcase
      prod      = ProdW'(op_a) * ProdW'(op_b);
      prod_half = shift17 ? ((ProdW+1)'(1) <<< 16) : ((ProdW+1)'(1) <<< 15);
      prod_rnd  = (shift17 ? (($signed({prod[ProdW-1], prod}) + prod_half) >>> 17)
                           : (($signed({prod[ProdW-1], prod}) + prod_half) >>> 16));
      rnd       = prod_rnd[RndW-1:0];
      base      = (cur.phase == PH_CUT) ? SumW'(cur.z_target) : SumW'(cur.origin_x);
      pos_sum   = (cur.phase == PH_RETRACT) ? (base - SumW'(rnd)) : (base + SumW'(rnd));
      pos_sat   = sat_pos(pos_sum);
   end

   always_comb begin
      nxt               = cur;
      has_rsp           = 1'b0;
      rsp.move_kind     = MOVE_SPINDLE;
      rsp.target_x      = cur.origin_x;
      rsp.target_z      = cur.z_target;
      rsp.feed_rate     = '0;
      unique case (cmd)
         CMD_ERROR: begin
            nxt.phase = PH_IDLE;
         end
         CMD_START: begin
            if (cur.phase == PH_IDLE) begin
               nxt.origin_x    = start_x;
               nxt.origin_z    = start_z;
               nxt.z_target    = start_z;
               nxt.cut_depth   = '0;
               nxt.active_feed = cfg.rough_feed;
               nxt.phase       = PH_PLUNGE;
               has_rsp         = 1'b1;
               rsp.move_kind   = MOVE_SPINDLE;
               rsp.target_x    = start_x;
               rsp.target_z    = start_z;
            end
         end
         CMD_DONE: begin
            unique case (cur.phase)
               PH_PLUNGE: begin
                  has_rsp = 1'b1;
                  if (diff == '0) begin
                     nxt.phase     = PH_IDLE;
                     rsp.move_kind = MOVE_DONE;
                     rsp.target_z  = cur.origin_z;
                  end else begin
                     nxt.cut_depth = new_cut;
                     if (take_finish) begin
                        nxt.active_feed = cfg.finish_feed;
                     end
                     nxt.phase     = PH_CUT;
                     rsp.move_kind = MOVE_RAPID_X;
                     rsp.target_x  = pos_sat;
                  end
               end
               PH_CUT: begin
                  has_rsp       = 1'b1;
                  nxt.z_target  = pos_sat;
                  nxt.phase     = PH_RETRACT;
                  rsp.move_kind = MOVE_FEED_XZ;
                  rsp.target_z  = pos_sat;
                  rsp.feed_rate = cur.active_feed;
               end
               PH_RETRACT: begin
                  has_rsp       = 1'b1;
                  nxt.phase     = PH_RETURN;
                  rsp.move_kind = MOVE_RAPID_X;
                  rsp.target_x  = pos_sat;
               end
               PH_RETURN: begin
                  has_rsp       = 1'b1;
                  nxt.z_target  = cur.origin_z;
                  nxt.phase     = PH_PLUNGE;
                  rsp.move_kind = MOVE_RAPID_XZ;
                  rsp.target_x  = pos_sat;
                  rsp.target_z  = cur.origin_z;
               end
               default: begin
                  nxt.phase = PH_IDLE;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

endmodule

### hw/rtl/cone_turning_pass_sequencer.sv
// ----------------------------------------------------------------------------
// cone_turning_pass_sequencer
// Multi-pass lathe cone cutting sequencer: spindle start, then plunge, cut,
// retract and return moves, one per move-done event, until the final depth.
//
//   channel  dir  handshake             payload
//   req_     in   req_tvalid/tready     tuser cmd, tdata start_x, start_z
//   rsp_     out  rsp_tvalid/tready     tuser move_kind, tdata targets, feed
//   csr_     in   csr_we                csr_addr index, csr_wdata value
//
// One request per cycle while the skid entry is empty; a move passes the
// request register, then the result register, after its request is taken.
// Reset is synchronous; it restores the register defaults and the idle phase.
// A two-entry result buffer absorbs rsp_tready stalls; req_tready drops only
// while its second entry is full.
// ----------------------------------------------------------------------------
module cone_turning_pass_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [1:0]                          req_tuser,   // cmd
   input  logic [47:0]                         req_tdata,   // start_x, start_z
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [2:0]                          rsp_tuser,   // move_kind
   output logic [63:0]                         rsp_tdata,   // target_x, target_z, feed_rate
   input  logic                                csr_we,
   input  logic [ctps_pkg::CsrAW-1:0]          csr_addr,
   input  logic [ctps_pkg::FactW-1:0]          csr_wdata
);
   import ctps_pkg::*;

   cfg_type                  cfg_ff;
   state_type                state_ff;
   state_type                state_in;

   logic                     req_valid_ff;
   logic                     req_valid_in;
   cmd_type                  req_cmd_ff;
   logic signed [PosW-1:0]   req_x_ff;
   logic signed [PosW-1:0]   req_z_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   rsp_type                  rsp_ff;
   logic                     skid_valid_ff;
   logic                     skid_valid_in;
   rsp_type                  skid_ff;

   logic                     req_take;
   logic                     step_fire;
   logic                     rsp_pop;
   logic                     has_rsp;
   rsp_type                  step_rsp;

   assign step_fire  = req_valid_ff && !skid_valid_ff;
   assign req_tready = !req_valid_ff || step_fire;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_pop    = rsp_valid_ff && rsp_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_depth  <= '0;
         cfg_ff.rough_depth  <= '0;
         cfg_ff.finish_depth <= '0;
         cfg_ff.retract_dist <= '0;
         cfg_ff.x_per_depth  <= FACTOR_ONE;
         cfg_ff.z_per_depth  <= FACTOR_ONE;
         cfg_ff.rough_feed   <= '0;
         cfg_ff.finish_feed  <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_TOTAL_DEPTH:  cfg_ff.total_depth  <= csr_wdata[DepthW-1:0];
            REG_ROUGH_DEPTH:  cfg_ff.rough_depth  <= csr_wdata[DepthW-1:0];
            REG_FINISH_DEPTH: cfg_ff.finish_depth <= csr_wdata[DepthW-1:0];
            REG_RETRACT_DIST: cfg_ff.retract_dist <= csr_wdata[DepthW-1:0];
            REG_X_PER_DEPTH:  cfg_ff.x_per_depth  <= $signed(csr_wdata);
            REG_Z_PER_DEPTH:  cfg_ff.z_per_depth  <= $signed(csr_wdata);
            REG_ROUGH_FEED:   cfg_ff.rough_feed   <= csr_wdata[FeedW-1:0];
            REG_FINISH_FEED:  cfg_ff.finish_feed  <= csr_wdata[FeedW-1:0];
         endcase
      end
   end

   // request register
   always_comb begin
      priority if (req_take) begin
         req_valid_in = 1'b1;
      end else if (step_fire) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_cmd_ff <= cmd_type'(req_tuser);
         req_x_ff   <= $signed(req_tdata[PosW-1:0]);
         req_z_ff   <= $signed(req_tdata[2*PosW-1:PosW]);
      end
   end

   ctps_step u_step (
      .cmd     (req_cmd_ff),
      .start_x (req_x_ff),
      .start_z (req_z_ff),
      .cfg     (cfg_ff),
      .cur     (state_ff),
      .nxt     (state_in),
      .has_rsp (has_rsp),
      .rsp     (step_rsp)
   );

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= PH_IDLE;
         state_ff.cut_depth   <= '0;
         state_ff.origin_x    <= '0;
         state_ff.origin_z    <= '0;
         state_ff.z_target    <= '0;
         state_ff.active_feed <= '0;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // result register with skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!rsp_valid_ff || rsp_pop) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = step_fire && has_rsp;
         end
      end else if (step_fire && has_rsp) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_pop) begin
         if (skid_valid_ff) begin
            rsp_ff <= skid_ff;
         end else begin
            rsp_ff <= step_rsp;
         end
      end
      if (rsp_valid_ff && !rsp_pop && step_fire && has_rsp) begin
         skid_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.move_kind;
   assign rsp_tdata  = {rsp_ff.feed_rate, rsp_ff.target_z, rsp_ff.target_x};

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cone turning pass sequencer. A request-level model
// of the pass logic predicts every move from each accepted request. Directed
// runs cover reset defaults, a full multi-pass cut, ignored and error commands
// and extreme settings; random cuts follow under many register settings, with
// random request gaps and result stalls.
// ----------------------------------------------------------------------------
module tb;
   import ctps_pkg::*;

   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam longint     POS_MAX       = 64'sd8388607;
   localparam longint     POS_MIN       = -64'sd8388608;
   localparam int         RANDOM_ITEMS  = 380;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         TIMEOUT_NS    = 5_000_000;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [1:0]          req_tuser;   // cmd
   logic [47:0]         req_tdata;   // start_x, start_z
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic [2:0]          rsp_tuser;   // move_kind
   logic [63:0]         rsp_tdata;   // target_x, target_z, feed_rate
   logic                csr_we;
   logic [CsrAW-1:0]    csr_addr;
   logic [FactW-1:0]    csr_wdata;

   // pass model
   cfg_type             cfg;
   phase_type           pass_phase;
   longint              depth_now, home_x, home_z, z_aim;
   logic [FeedW-1:0]    feed_now;

   rsp_type             pending_moves[$];
   rsp_type             head_move;
   int                  acted_requests;
   int                  mismatches;
   int                  stall_left = 0;
   bit                  idle_on = 1'b1;

   cone_turning_pass_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint round_shift(input longint p, input int sh);
      return (p + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic logic signed [PosW-1:0] clamp_pos(input longint v);
      if (v > POS_MAX) v = POS_MAX;
      else if (v < POS_MIN) v = POS_MIN;
      return v[PosW-1:0];
   endfunction

   function automatic bit predict_move(input logic [1:0] cmd,
                                       input logic signed [PosW-1:0] sx,
                                       input logic signed [PosW-1:0] sz,
                                       output rsp_type mv);
      longint total, diff, x, rough, fin, ret, xf, zf;
      total = cfg.total_depth;
      rough = cfg.rough_depth;
      fin   = cfg.finish_depth;
      ret   = cfg.retract_dist;
      xf    = cfg.x_per_depth;
      zf    = cfg.z_per_depth;
      mv    = '0;
      case (cmd)
         CMD_ERROR: begin
            pass_phase = PH_IDLE;
            return 1'b0;
         end
         CMD_START: begin
            if (pass_phase != PH_IDLE) return 1'b0;
            home_x     = sx;
            home_z     = sz;
            z_aim      = home_z;
            depth_now  = 0;
            feed_now   = cfg.rough_feed;
            pass_phase = PH_PLUNGE;
            mv.move_kind = MOVE_SPINDLE;
            mv.target_x  = sx;
            mv.target_z  = sz;
            return 1'b1;
         end
         CMD_DONE: ;
         default: return 1'b0;
      endcase
      case (pass_phase)
         PH_PLUNGE: begin
            diff = total - depth_now;
            if (diff == 0) begin
               pass_phase   = PH_IDLE;
               mv.move_kind = MOVE_DONE;
               mv.target_x  = clamp_pos(home_x);
               mv.target_z  = clamp_pos(home_z);
               return 1'b1;
            end
            if (diff >= rough + fin) begin
               depth_now = depth_now + rough;
            end else if (diff <= fin + 1) begin
               depth_now = total;
               feed_now  = cfg.finish_feed;
            end else begin
               depth_now = total - fin;
            end
            x = home_x + round_shift(depth_now * xf, 17);
            pass_phase   = PH_CUT;
            mv.move_kind = MOVE_RAPID_X;
            mv.target_x  = clamp_pos(x);
            mv.target_z  = clamp_pos(z_aim);
         end
         PH_CUT: begin
            z_aim = clamp_pos(z_aim + round_shift(depth_now * zf, 16));
            pass_phase   = PH_RETRACT;
            mv.move_kind = MOVE_FEED_XZ;
            mv.target_x  = clamp_pos(home_x);
            mv.target_z  = clamp_pos(z_aim);
            mv.feed_rate = feed_now;
         end
         PH_RETRACT: begin
            x = home_x - round_shift(ret * xf, 16);
            pass_phase   = PH_RETURN;
            mv.move_kind = MOVE_RAPID_X;
            mv.target_x  = clamp_pos(x);
            mv.target_z  = clamp_pos(z_aim);
         end
         PH_RETURN: begin
            z_aim = home_z;
            x = home_x + round_shift((depth_now - ret) * xf, 17);
            pass_phase   = PH_PLUNGE;
            mv.move_kind = MOVE_RAPID_XZ;
            mv.target_x  = clamp_pos(x);
            mv.target_z  = clamp_pos(z_aim);
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("tb: mismatch: %s", msg);
   endtask

   task automatic send_request(input logic [1:0] cmd,
                               input logic signed [PosW-1:0] sx,
                               input logic signed [PosW-1:0] sz);
      rsp_type mv;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {sz, sx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (predict_move(cmd, sx, sz, mv)) begin
         pending_moves.push_back(mv);
         acted_requests++;
      end else if (cmd == CMD_ERROR) begin
         acted_requests++;
      end
      @(negedge clock);
   endtask

   // wait out every pending move, then the pipeline
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_moves.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic put_reg(input logic [CsrAW-1:0] idx, input logic [FactW-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic program_regs(input cfg_type c);
      put_reg(REG_TOTAL_DEPTH, FactW'(c.total_depth));
      put_reg(REG_ROUGH_DEPTH, FactW'(c.rough_depth));
      put_reg(REG_FINISH_DEPTH, FactW'(c.finish_depth));
      put_reg(REG_RETRACT_DIST, FactW'(c.retract_dist));
      put_reg(REG_X_PER_DEPTH, c.x_per_depth);
      put_reg(REG_Z_PER_DEPTH, c.z_per_depth);
      put_reg(REG_ROUGH_FEED, FactW'(c.rough_feed));
      put_reg(REG_FINISH_FEED, FactW'(c.finish_feed));
      csr_we <= 1'b0;
      cfg = c;
   endtask

   function automatic logic signed [PosW-1:0] pick_pos();
      case ($urandom_range(0, 7))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return '0;
         default: return PosW'($urandom);
      endcase
   endfunction

   function automatic logic signed [FactW-1:0] pick_factor();
      case ($urandom_range(0, 9))
         0: return 25'sh0FFFFFF;
         1: return 25'sh1000000;
         2: return '0;
         3: return FACTOR_ONE;
         4: return -FACTOR_ONE;
         5, 6: return FactW'($urandom);
         default: return FactW'(int'($urandom_range(0, 262144)) - 131072);
      endcase
   endfunction

   function automatic cfg_type random_setting();
      cfg_type c;
      c.total_depth  = ($urandom_range(0, 4) == 0) ? 20'hFFFFF
                                                   : 20'($urandom_range(0, 6000));
      c.rough_depth  = ($urandom_range(0, 19) == 0) ? '0
                       : 20'(c.total_depth / $urandom_range(1, 5) + $urandom_range(0, 3));
      c.finish_depth = ($urandom_range(0, 7) == 0) ? 20'($urandom)
                       : 20'(c.total_depth / $urandom_range(2, 12));
      c.retract_dist = ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                                   : 20'($urandom_range(0, 2000));
      c.x_per_depth  = pick_factor();
      c.z_per_depth  = pick_factor();
      c.rough_feed   = 16'($urandom);
      c.finish_feed  = 16'($urandom);
      return c;
   endfunction

   // one cut from start, with noise, aborted by error past max_done
   task automatic run_cut(input int max_done);
      int n;
      n = 0;
      send_request(CMD_START, pick_pos(), pick_pos());
      while (pass_phase != PH_IDLE && n < max_done) begin
         case ($urandom_range(0, 39))
            0: send_request(CMD_START, pick_pos(), pick_pos());
            1: send_request(CMD_UNUSED, pick_pos(), pick_pos());
            2: send_request(CMD_ERROR, pick_pos(), pick_pos());
            default: begin
               send_request(CMD_DONE, pick_pos(), pick_pos());
               n++;
            end
         endcase
      end
      if (pass_phase != PH_IDLE) send_request(CMD_ERROR, pick_pos(), pick_pos());
      else if ($urandom_range(0, 3) == 0) send_request(CMD_DONE, pick_pos(), pick_pos());
   endtask

   task automatic test_reset_defaults();
      // zero total depth: the first done ends the cut
      send_request(CMD_START, 24'sh7FFFFF, 24'sh800000);
      send_request(CMD_DONE, '0, '0);
      send_request(CMD_DONE, 24'sh7FFFFF, 24'sh7FFFFF);
   endtask

   task automatic test_pass_sequence();
      cfg_type c;
      settle();
      c.total_depth  = 20'd100;
      c.rough_depth  = 20'd40;
      c.finish_depth = 20'd10;
      c.retract_dist = 20'd25;
      c.x_per_depth  = -FACTOR_ONE;
      c.z_per_depth  = 25'sh0FFFFFF;
      c.rough_feed   = 16'hFFFF;
      c.finish_feed  = 16'd1;
      program_regs(c);
      send_request(CMD_START, 24'sd1000, -24'sd5000);
      send_request(CMD_DONE, '0, '0);
      send_request(CMD_START, 24'sd7, 24'sd9);
      send_request(CMD_DONE, '0, '0);
      send_request(CMD_UNUSED, 24'sh800000, 24'sh7FFFFF);
      while (pass_phase != PH_IDLE) send_request(CMD_DONE, '0, '0);
      send_request(CMD_DONE, '0, '0);
   endtask

   task automatic test_error_recovery();
      send_request(CMD_ERROR, '0, '0);
      send_request(CMD_START, -24'sd300, 24'sd400);
      send_request(CMD_DONE, '0, '0);
      send_request(CMD_DONE, '0, '0);
      send_request(CMD_ERROR, '0, '0);
      send_request(CMD_DONE, '0, '0);
      send_request(CMD_START, 24'sd12, -24'sd34);
      send_request(CMD_DONE, '0, '0);
      send_request(CMD_ERROR, '0, '0);
   endtask

   task automatic test_extreme_settings();
      cfg_type c;
      settle();
      c.total_depth  = 20'hFFFFF;
      c.rough_depth  = 20'hFFFFF;
      c.finish_depth = 20'hFFFFF;
      c.retract_dist = 20'hFFFFF;
      c.x_per_depth  = 25'sh0FFFFFF;
      c.z_per_depth  = 25'sh1000000;
      c.rough_feed   = 16'hFFFF;
      c.finish_feed  = 16'hFFFF;
      program_regs(c);
      run_cut(10);
      run_cut(10);
      settle();
      // zero rough depth repeats the same pass until aborted
      c.total_depth  = 20'd1000;
      c.rough_depth  = '0;
      c.finish_depth = '0;
      c.retract_dist = '0;
      c.x_per_depth  = 25'sh1000000;
      c.z_per_depth  = 25'sh0FFFFFF;
      c.rough_feed   = '0;
      c.finish_feed  = '0;
      program_regs(c);
      run_cut(12);
   endtask

   task automatic test_random_cuts();
      int phase_end;
      acted_requests = 0;
      while (acted_requests < RANDOM_ITEMS) begin
         settle();
         program_regs(random_setting());
         idle_on = (acted_requests < RANDOM_ITEMS - 60) && ($urandom_range(0, 3) != 0);
         phase_end = acted_requests + 60;
         while (acted_requests < phase_end && acted_requests < RANDOM_ITEMS) run_cut(40);
      end
   endtask

   // result stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_moves.size() == 0) begin
            report_mismatch($sformatf("move kind %0d with none pending", rsp_tuser));
         end else begin
            head_move = pending_moves.pop_front();
            if (rsp_tuser !== head_move.move_kind)
               report_mismatch($sformatf("move_kind got %0d expected %0d",
                                         rsp_tuser, head_move.move_kind));
            if (rsp_tdata[23:0] !== head_move.target_x)
               report_mismatch($sformatf("target_x got %0d expected %0d",
                                         $signed(rsp_tdata[23:0]), head_move.target_x));
            if (rsp_tdata[47:24] !== head_move.target_z)
               report_mismatch($sformatf("target_z got %0d expected %0d",
                                         $signed(rsp_tdata[47:24]), head_move.target_z));
            if (rsp_tdata[63:48] !== head_move.feed_rate)
               report_mismatch($sformatf("feed_rate got %0d expected %0d",
                                         rsp_tdata[63:48], head_move.feed_rate));
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      mismatches = 0;
      acted_requests = 0;
      cfg = '0;
      cfg.x_per_depth = FACTOR_ONE;
      cfg.z_per_depth = FACTOR_ONE;
      pass_phase = PH_IDLE;
      depth_now  = 0;
      home_x     = 0;
      home_z     = 0;
      z_aim      = 0;
      feed_now   = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_pass_sequence();
      test_error_recovery();
      test_extreme_settings();
      test_random_cuts();
      settle();

      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb: run timed out");
      $display("tb: FAIL");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/ctps_pkg.sv
hw/rtl/ctps_step.sv
hw/rtl/cone_turning_pass_sequencer.sv
verif/tb.sv
